@@ rtl/heap_timeout_scheduler_core_assert.svh @@
// Assertion macros for the timeout scheduler core.
// Included by the modules that check their own logic; no other dependencies.
`ifndef HEAP_TIMEOUT_SCHEDULER_CORE_ASSERT_SVH
`define HEAP_TIMEOUT_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTH
`define HTSCH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("htsch assertion failed");
`define HTSCH_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("htsch forbidden condition seen");
`else
`define HTSCH_ASSERT(lbl, clk, rst, prop)
`define HTSCH_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ rtl/htsch_pkg.sv @@
// Shared types and constants of the timeout scheduler core.
// No dependencies.
package htsch_pkg;

   localparam int KEY_W     = 10;
   localparam int TO_W      = 24;
   localparam int COUNT_W   = 7;
   localparam int ID_SPAN_W = 17;

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_ADJUST = 3'd1;
   localparam logic [2:0] CMD_TICK   = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [TO_W-1:0] WAIT_MAX = '1;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [KEY_W-1:0] key_id;
      logic [TO_W-1:0]  timeout_ms;
   } req_type;

   typedef struct packed {
      logic               expired;
      logic [KEY_W-1:0]   expired_id;
      logic [1:0]         status;
      logic               queue_empty;
      logic [TO_W-1:0]    next_wait;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_CHECK,
      S_LOAD_LAST,
      S_SD_LEFT,
      S_SD_RIGHT,
      S_SD_PICK,
      S_SU_RD,
      S_SU_CMP,
      S_PLACE,
      S_ROOT_RD,
      S_ROOT
   } state_type;

endpackage

@@ rtl/htsch_chan_if.sv @@
// Valid/ready channel carrying one payload beat.
// Payload type is set per instance; no package dependency.
interface htsch_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/htsch_heap_ram.sv @@
// Heap slot memory: expiry time and owner id per slot, one write and one
// registered read port. Uses htsch_pkg.
module htsch_heap_ram import htsch_pkg::*; #(
   parameter int CAPACITY  = 64,
   parameter int TIME_BITS = 32,
   localparam int SlotW    = $clog2(CAPACITY)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SlotW-1:0]     wr_addr,
   input  logic [TIME_BITS-1:0] wr_expiry,
   input  logic [KEY_W-1:0]     wr_owner,
   input  logic                 rd_en,
   input  logic [SlotW-1:0]     rd_addr,
   output logic [TIME_BITS-1:0] rd_expiry,
   output logic [KEY_W-1:0]     rd_owner
);

   logic [TIME_BITS-1:0] expiry_mem [CAPACITY];
   logic [KEY_W-1:0]     owner_mem  [CAPACITY];
   logic [TIME_BITS-1:0] rd_expiry_ff;
   logic [KEY_W-1:0]     rd_owner_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         expiry_mem[wr_addr] <= wr_expiry;
         owner_mem[wr_addr]  <= wr_owner;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_expiry_ff <= expiry_mem[rd_addr];
         rd_owner_ff  <= owner_mem[rd_addr];
      end
   end

   assign rd_expiry = rd_expiry_ff;
   assign rd_owner  = rd_owner_ff;

endmodule

@@ rtl/htsch_id_table.sv @@
// Id table: presence bit and heap slot per connection id, each with its own
// write port and a shared registered read address. Uses htsch_pkg.
module htsch_id_table import htsch_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int MAX_IDS  = 1024,
   localparam int SlotW   = $clog2(CAPACITY),
   localparam int IdxW    = $clog2(MAX_IDS)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IdxW-1:0]  rd_addr,
   output logic             rd_present,
   output logic [SlotW-1:0] rd_slot,
   input  logic             pres_wr_en,
   input  logic [IdxW-1:0]  pres_wr_addr,
   input  logic             pres_wr_value,
   input  logic             slot_wr_en,
   input  logic [IdxW-1:0]  slot_wr_addr,
   input  logic [SlotW-1:0] slot_wr_value
);

   logic             present_mem [MAX_IDS];
   logic [SlotW-1:0] slot_mem    [MAX_IDS];
   logic             rd_present_ff;
   logic [SlotW-1:0] rd_slot_ff;

   always_ff @(posedge clock) begin
      if (pres_wr_en) begin
         present_mem[pres_wr_addr] <= pres_wr_value;
      end
      if (slot_wr_en) begin
         slot_mem[slot_wr_addr] <= slot_wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_present_ff <= present_mem[rd_addr];
         rd_slot_ff    <= slot_mem[rd_addr];
      end
   end

   assign rd_present = rd_present_ff;
   assign rd_slot    = rd_slot_ff;

endmodule

@@ rtl/htsch_ctrl.sv @@
// Command sequencer: decodes commands, runs sift-up and sift-down over the
// heap memory, keeps the id table in step and builds result beats.
// Uses htsch_pkg and heap_timeout_scheduler_core_assert.svh.
`include "heap_timeout_scheduler_core_assert.svh"
module htsch_ctrl import htsch_pkg::*; #(
   parameter int CAPACITY  = 64,
   parameter int MAX_IDS   = 1024,
   parameter int TIME_BITS = 32,
   localparam int SlotW    = $clog2(CAPACITY),
   localparam int SizeW    = $clog2(CAPACITY + 1),
   localparam int IdxW     = $clog2(MAX_IDS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_type              req_data,
   output logic                 req_ready,
   input  logic                 out_free,
   output logic                 emit_valid,
   output rsp_type              emit_data,
   output logic                 heap_rd_en,
   output logic [SlotW-1:0]     heap_rd_addr,
   input  logic [TIME_BITS-1:0] heap_rd_expiry,
   input  logic [KEY_W-1:0]     heap_rd_owner,
   output logic                 heap_wr_en,
   output logic [SlotW-1:0]     heap_wr_addr,
   output logic [TIME_BITS-1:0] heap_wr_expiry,
   output logic [KEY_W-1:0]     heap_wr_owner,
   output logic                 id_rd_en,
   output logic [IdxW-1:0]      id_rd_addr,
   input  logic                 id_rd_present,
   input  logic [SlotW-1:0]     id_rd_slot,
   output logic                 pres_wr_en,
   output logic [IdxW-1:0]      pres_wr_addr,
   output logic                 pres_wr_value,
   output logic                 slot_wr_en,
   output logic [IdxW-1:0]      slot_wr_addr,
   output logic [SlotW-1:0]     slot_wr_value
);

   localparam int CmpW = SlotW + 2;

   function automatic logic earlier(input logic [TIME_BITS-1:0] a,
                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] d;
      d = a - b;
      return d[TIME_BITS-1];
   endfunction

   function automatic logic [IdxW-1:0] id_index(input logic [KEY_W-1:0] k);
      logic [ID_SPAN_W-1:0] w;
      w = ID_SPAN_W'(k);
      return w[IdxW-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [2:0]           op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [TO_W-1:0]      to_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [SizeW-1:0]     size_ff;
   logic [1:0]           status_ff;
   logic [TIME_BITS-1:0] elem_exp_ff;
   logic [KEY_W-1:0]     elem_own_ff;
   logic [SlotW-1:0]     hole_ff;
   logic                 moved_ff;
   logic                 has_right_ff;
   logic [TIME_BITS-1:0] left_exp_ff;
   logic [KEY_W-1:0]     left_own_ff;
   logic [KEY_W-1:0]     who_ff;
   logic                 popped_ff;
   logic [IdxW-1:0]      clr_cnt_ff;
   logic                 clr_rsp_ff;

   // Decisions
   logic [CmpW-1:0]      left_idx, right_idx, size_w;
   logic                 has_left, has_right_now;
   logic                 pick_right, sd_stop, su_stop;
   logic [TIME_BITS-1:0] child_exp;
   logic [KEY_W-1:0]     child_own;
   logic [SlotW-1:0]     child_idx, parent_idx;
   logic [TIME_BITS-1:0] root_diff, new_expiry;
   logic                 root_due, pop_cond;
   logic                 pop_raw, emit_raw, emit_last, emit_exp, root_stall, pop_go;
   logic [TO_W-1:0]      wait_val;
   logic                 in_range, is_known, is_add_new;
   logic [SizeW-1:0]     size_dec;

   always_comb begin
      left_idx      = CmpW'({hole_ff, 1'b1});
      right_idx     = left_idx + CmpW'(1);
      size_w        = CmpW'(size_ff);
      has_left      = left_idx < size_w;
      has_right_now = right_idx < size_w;
      pick_right    = has_right_ff && earlier(heap_rd_expiry, left_exp_ff);
      child_exp     = pick_right ? heap_rd_expiry : left_exp_ff;
      child_own     = pick_right ? heap_rd_owner : left_own_ff;
      child_idx     = pick_right ? right_idx[SlotW-1:0] : left_idx[SlotW-1:0];
      sd_stop       = earlier(elem_exp_ff, child_exp);
      su_stop       = earlier(heap_rd_expiry, elem_exp_ff);
      parent_idx    = (hole_ff - SlotW'(1)) >> 1;
      new_expiry    = now_ff + TIME_BITS'(to_ff);
      size_dec      = size_ff - SizeW'(1);

      in_range   = ID_SPAN_W'(key_ff) < ID_SPAN_W'(MAX_IDS);
      is_known   = in_range && id_rd_present;
      is_add_new = in_range && !id_rd_present && (op_ff == CMD_ADD)
                   && (size_ff != SizeW'(CAPACITY));

      root_diff = heap_rd_expiry - now_ff;
      root_due  = (root_diff == '0) || root_diff[TIME_BITS-1];
      pop_cond  = (size_ff != '0) && root_due;
      if ((size_ff == '0) || root_diff[TIME_BITS-1]) begin
         wait_val = '0;
      end else if (root_diff > TIME_BITS'(WAIT_MAX)) begin
         wait_val = WAIT_MAX;
      end else begin
         wait_val = root_diff[TO_W-1:0];
      end

      pop_raw   = 1'b0;
      emit_raw  = 1'b1;
      emit_last = 1'b1;
      emit_exp  = 1'b0;
      case (op_ff)
         CMD_TICK: begin
            pop_raw   = pop_cond;
            emit_raw  = popped_ff || !pop_cond;
            emit_last = !pop_cond;
            emit_exp  = popped_ff;
         end
         CMD_REMOVE: begin
            pop_raw  = !popped_ff && (size_ff != '0);
            emit_raw = !pop_raw;
         end
         default: begin
            pop_raw = 1'b0;
         end
      endcase
      root_stall = emit_raw && !out_free;
      pop_go     = (state_ff == S_ROOT) && pop_raw && !root_stall;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == IdxW'(MAX_IDS - 1)) begin
               state_in = clr_rsp_ff ? S_ROOT_RD : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  CMD_ADD, CMD_ADJUST: state_in = S_LOOKUP;
                  CMD_CLEAR:           state_in = S_CLEAR;
                  default:             state_in = S_ROOT_RD;
               endcase
            end
         end
         S_LOOKUP: state_in = S_CHECK;
         S_CHECK: begin
            if (is_known) begin
               state_in = S_SD_LEFT;
            end else if (is_add_new) begin
               state_in = S_SU_RD;
            end else begin
               state_in = S_ROOT_RD;
            end
         end
         S_LOAD_LAST: state_in = S_SD_LEFT;
         S_SD_LEFT: begin
            if (has_left) begin
               state_in = S_SD_RIGHT;
            end else begin
               state_in = moved_ff ? S_PLACE : S_SU_RD;
            end
         end
         S_SD_RIGHT: state_in = S_SD_PICK;
         S_SD_PICK: begin
            if (sd_stop) begin
               state_in = moved_ff ? S_PLACE : S_SU_RD;
            end else begin
               state_in = S_SD_LEFT;
            end
         end
         S_SU_RD: state_in = (hole_ff == '0) ? S_PLACE : S_SU_CMP;
         S_SU_CMP: state_in = su_stop ? S_PLACE : S_SU_RD;
         S_PLACE: state_in = S_ROOT_RD;
         S_ROOT_RD: state_in = S_ROOT;
         S_ROOT: begin
            if (!root_stall) begin
               if (pop_raw) begin
                  state_in = (size_dec != '0) ? S_LOAD_LAST : S_ROOT_RD;
               end else if (emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory controls and result beat
   always_comb begin
      req_ready      = 1'b0;
      heap_rd_en     = 1'b0;
      heap_rd_addr   = '0;
      heap_wr_en     = 1'b0;
      heap_wr_addr   = hole_ff;
      heap_wr_expiry = elem_exp_ff;
      heap_wr_owner  = elem_own_ff;
      id_rd_en       = 1'b0;
      id_rd_addr     = id_index(key_ff);
      pres_wr_en     = 1'b0;
      pres_wr_addr   = id_index(key_ff);
      pres_wr_value  = 1'b0;
      slot_wr_en     = 1'b0;
      slot_wr_addr   = id_index(elem_own_ff);
      slot_wr_value  = hole_ff;
      emit_valid     = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            pres_wr_en   = 1'b1;
            pres_wr_addr = clr_cnt_ff;
         end
         S_IDLE: req_ready = 1'b1;
         S_LOOKUP: id_rd_en = 1'b1;
         S_CHECK: begin
            if (is_add_new) begin
               pres_wr_en    = 1'b1;
               pres_wr_value = 1'b1;
            end
         end
         S_SD_LEFT: begin
            heap_rd_en   = has_left;
            heap_rd_addr = left_idx[SlotW-1:0];
         end
         S_SD_RIGHT: begin
            heap_rd_en   = has_right_now;
            heap_rd_addr = right_idx[SlotW-1:0];
         end
         S_SD_PICK: begin
            // move the earlier child up into the hole
            if (!sd_stop) begin
               heap_wr_en     = 1'b1;
               heap_wr_expiry = child_exp;
               heap_wr_owner  = child_own;
               slot_wr_en     = 1'b1;
               slot_wr_addr   = id_index(child_own);
            end
         end
         S_SU_RD: begin
            heap_rd_en   = (hole_ff != '0);
            heap_rd_addr = parent_idx;
         end
         S_SU_CMP: begin
            // move the parent down into the hole
            if (!su_stop) begin
               heap_wr_en     = 1'b1;
               heap_wr_expiry = heap_rd_expiry;
               heap_wr_owner  = heap_rd_owner;
               slot_wr_en     = 1'b1;
               slot_wr_addr   = id_index(heap_rd_owner);
            end
         end
         S_PLACE: begin
            heap_wr_en = 1'b1;
            slot_wr_en = 1'b1;
         end
         S_ROOT_RD: begin
            heap_rd_en   = 1'b1;
            heap_rd_addr = '0;
         end
         S_ROOT: begin
            emit_valid   = emit_raw && !root_stall;
            // drop the root owner and fetch the last slot to refill the root
            pres_wr_en   = pop_go;
            pres_wr_addr = id_index(heap_rd_owner);
            heap_rd_en   = pop_go && (size_dec != '0);
            heap_rd_addr = size_dec[SlotW-1:0];
         end
         default: req_ready = 1'b0;
      endcase

      emit_data.expired     = emit_exp;
      emit_data.expired_id  = emit_exp ? who_ff : '0;
      emit_data.status      = status_ff;
      emit_data.queue_empty = (size_ff == '0);
      emit_data.next_wait   = wait_val;
      emit_data.entry_count = COUNT_W'(size_ff);
      emit_data.last        = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         now_ff     <= '0;
         size_ff    <= '0;
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         popped_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_CLEAR: clr_cnt_ff <= clr_cnt_ff + IdxW'(1);
            S_IDLE: begin
               if (req_valid) begin
                  op_ff      <= req_data.cmd;
                  key_ff     <= req_data.key_id;
                  to_ff      <= req_data.timeout_ms;
                  status_ff  <= ST_OK;
                  popped_ff  <= 1'b0;
                  clr_rsp_ff <= 1'b0;
                  if (req_data.cmd == CMD_TICK) begin
                     now_ff <= now_ff + TIME_BITS'(1);
                  end
                  if (req_data.cmd == CMD_CLEAR) begin
                     size_ff    <= '0;
                     clr_cnt_ff <= '0;
                     clr_rsp_ff <= 1'b1;
                  end
               end
            end
            S_CHECK: begin
               elem_exp_ff <= new_expiry;
               elem_own_ff <= key_ff;
               moved_ff    <= 1'b0;
               if (is_known) begin
                  hole_ff <= id_rd_slot;
               end else if (is_add_new) begin
                  hole_ff <= size_ff[SlotW-1:0];
                  size_ff <= size_ff + SizeW'(1);
               end else if (!in_range || op_ff == CMD_ADJUST) begin
                  status_ff <= ST_UNKNOWN;
               end else begin
                  status_ff <= ST_FULL;
               end
            end
            S_LOAD_LAST: begin
               elem_exp_ff <= heap_rd_expiry;
               elem_own_ff <= heap_rd_owner;
               hole_ff     <= '0;
               moved_ff    <= 1'b0;
            end
            S_SD_RIGHT: begin
               left_exp_ff  <= heap_rd_expiry;
               left_own_ff  <= heap_rd_owner;
               has_right_ff <= has_right_now;
            end
            S_SD_PICK: begin
               if (!sd_stop) begin
                  hole_ff  <= child_idx;
                  moved_ff <= 1'b1;
               end
            end
            S_SU_CMP: begin
               if (!su_stop) begin
                  hole_ff <= parent_idx;
               end
            end
            S_ROOT: begin
               if (pop_go) begin
                  who_ff    <= heap_rd_owner;
                  popped_ff <= 1'b1;
                  size_ff   <= size_dec;
               end
            end
            default: begin
               clr_rsp_ff <= clr_rsp_ff;
            end
         endcase
      end
   end

   `HTSCH_NEVER(a_size_bound, clock, reset, size_ff > SizeW'(CAPACITY))
   `HTSCH_ASSERT(a_emit_room, clock, reset, emit_valid |-> out_free)
   `HTSCH_ASSERT(a_pop_shrinks, clock, reset, pop_go |=> size_ff == $past(size_dec))
   `HTSCH_ASSERT(a_hole_live, clock, reset, (state_ff == S_SD_LEFT || state_ff == S_SU_RD) |-> SizeW'(hole_ff) < size_ff)

endmodule

@@ rtl/heap_timeout_scheduler_core.sv @@
// Channel | dir | payload                                   | beats
// req_if  | in  | cmd, key_id, timeout_ms                   | one per command
// rsp_if  | out | expired, expired_id, status, queue_empty, | one or more per command,
//         |     | next_wait, entry_count, last              | last marks the final one
//
// Commands run one at a time: a lookup steps through S_LOOKUP and S_CHECK, sift-down
// steps through S_SD_LEFT, S_SD_RIGHT and S_SD_PICK per heap level and sift-up through
// S_SU_RD and S_SU_CMP, paced by the heap memory's single read port. Every result reads
// the root in S_ROOT_RD and S_ROOT. After reset and on clear the id presence memory is
// swept one entry a cycle, with req_if held off. A stalled rsp_if beat holds in the
// output register; the next command is taken meanwhile but its result waits for room.
// Uses htsch_pkg, htsch_chan_if, htsch_ctrl, htsch_heap_ram and htsch_id_table.
module heap_timeout_scheduler_core import htsch_pkg::*; #(
   parameter int CAPACITY  = 64,
   parameter int MAX_IDS   = 1024,
   parameter int TIME_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   htsch_chan_if.sink   req_if,
   htsch_chan_if.source rsp_if
);

   localparam int SlotW = $clog2(CAPACITY);
   localparam int IdxW  = $clog2(MAX_IDS);

   logic                 out_free, emit_valid;
   rsp_type              emit_data;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic                 heap_rd_en, heap_wr_en;
   logic [SlotW-1:0]     heap_rd_addr, heap_wr_addr;
   logic [TIME_BITS-1:0] heap_rd_expiry, heap_wr_expiry;
   logic [KEY_W-1:0]     heap_rd_owner, heap_wr_owner;
   logic                 id_rd_en, id_rd_present;
   logic [IdxW-1:0]      id_rd_addr, pres_wr_addr, slot_wr_addr;
   logic [SlotW-1:0]     id_rd_slot, slot_wr_value;
   logic                 pres_wr_en, pres_wr_value, slot_wr_en;

   htsch_ctrl #(
      .CAPACITY (CAPACITY),
      .MAX_IDS  (MAX_IDS),
      .TIME_BITS(TIME_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_data      (req_if.data),
      .req_ready     (req_if.ready),
      .out_free      (out_free),
      .emit_valid    (emit_valid),
      .emit_data     (emit_data),
      .heap_rd_en    (heap_rd_en),
      .heap_rd_addr  (heap_rd_addr),
      .heap_rd_expiry(heap_rd_expiry),
      .heap_rd_owner (heap_rd_owner),
      .heap_wr_en    (heap_wr_en),
      .heap_wr_addr  (heap_wr_addr),
      .heap_wr_expiry(heap_wr_expiry),
      .heap_wr_owner (heap_wr_owner),
      .id_rd_en      (id_rd_en),
      .id_rd_addr    (id_rd_addr),
      .id_rd_present (id_rd_present),
      .id_rd_slot    (id_rd_slot),
      .pres_wr_en    (pres_wr_en),
      .pres_wr_addr  (pres_wr_addr),
      .pres_wr_value (pres_wr_value),
      .slot_wr_en    (slot_wr_en),
      .slot_wr_addr  (slot_wr_addr),
      .slot_wr_value (slot_wr_value)
   );

   htsch_heap_ram #(
      .CAPACITY (CAPACITY),
      .TIME_BITS(TIME_BITS)
   ) u_heap_ram (
      .clock    (clock),
      .wr_en    (heap_wr_en),
      .wr_addr  (heap_wr_addr),
      .wr_expiry(heap_wr_expiry),
      .wr_owner (heap_wr_owner),
      .rd_en    (heap_rd_en),
      .rd_addr  (heap_rd_addr),
      .rd_expiry(heap_rd_expiry),
      .rd_owner (heap_rd_owner)
   );

   htsch_id_table #(
      .CAPACITY(CAPACITY),
      .MAX_IDS (MAX_IDS)
   ) u_id_table (
      .clock        (clock),
      .rd_en        (id_rd_en),
      .rd_addr      (id_rd_addr),
      .rd_present   (id_rd_present),
      .rd_slot      (id_rd_slot),
      .pres_wr_en   (pres_wr_en),
      .pres_wr_addr (pres_wr_addr),
      .pres_wr_value(pres_wr_value),
      .slot_wr_en   (slot_wr_en),
      .slot_wr_addr (slot_wr_addr),
      .slot_wr_value(slot_wr_value)
   );

   // Output register: a new beat loads when the held one is gone or leaving
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule
